// File: sv/lptf_pkg.sv
// Shared types, frame constants and the control-store program of the page transpose framer.
// Used by lptf_seq and lcd_page_transpose_framer; depends on nothing else.
package lptf_pkg;

  // Scan geometry limits.
  localparam int MAX_GROUPS = 8;
  localparam int MAX_PAGES  = 16;

  // Frame bytes sent to the panel.
  localparam logic [7:0] FRAME_SYNC   = 8'ha5;
  localparam logic [7:0] FRAME_LEN    = 8'h05;
  localparam logic [7:0] FRAME_CMD    = 8'h03;
  localparam logic [7:0] FRAME_DATA   = 8'h22;
  localparam logic [7:0] FRAME_ZERO   = 8'h00;
  localparam logic [7:0] FRAME_ONE    = 8'h01;
  localparam logic [7:0] CMD_PAGE     = 8'hb0;
  localparam logic [7:0] CMD_COL_HI   = 8'h10;
  // The column address is always 4 + 32 * group, so its low nibble is fixed.
  localparam logic [7:0] CMD_COL_LO   = 8'h04;

  // Configuration register indexes.
  localparam logic [1:0] REG_INVERT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Program layout.
  localparam int PC_W       = 5;
  localparam int DCNT_W     = 5;
  localparam logic [PC_W-1:0]   STEP_COL_FRAME = 5'd6;
  localparam logic [PC_W-1:0]   STEP_DATA      = 5'd20;
  localparam logic [DCNT_W-1:0] DATA_LAST      = 5'd31;

  // Source of the byte a control word emits.
  typedef enum logic [1:0] {
    SRC_CONST,
    SRC_PAGE,
    SRC_COLHI,
    SRC_DATA
  } lptf_src_t;

  // Sequencing of a control word.
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_IF_GROUP,
    JMP_DATA_LOOP
  } lptf_jmp_t;

  // One control word of the program.
  typedef struct packed {
    logic             emit;
    lptf_src_t        src;
    logic [7:0]       konst;
    lptf_jmp_t        jmp;
    logic [PC_W-1:0]  target;
  } lptf_uword_t;

  // What the sequencer hands the datapath in the current step.
  typedef struct packed {
    logic       emit;
    lptf_src_t  src;
    logic [7:0] konst;
    logic       last;
  } lptf_step_t;

  // Control store: page frame (skipped past group zero), two column frames,
  // the data header, and the 32-byte data loop.
  function automatic lptf_uword_t lptf_rom(input logic [PC_W-1:0] pc);
    lptf_uword_t w;
    w = '{emit: 1'b1, src: SRC_CONST, konst: FRAME_ZERO, jmp: JMP_NEXT, target: '0};
    unique case (pc)
      5'd0: begin
        w.emit   = 1'b0;
        w.jmp    = JMP_IF_GROUP;
        w.target = STEP_COL_FRAME;
      end
      5'd1:  w.konst = FRAME_SYNC;
      5'd2:  w.konst = FRAME_LEN;
      5'd3:  w.konst = FRAME_CMD;
      5'd4:  w.konst = FRAME_ZERO;
      5'd5:  w.src   = SRC_PAGE;
      5'd6:  w.konst = FRAME_SYNC;
      5'd7:  w.konst = FRAME_LEN;
      5'd8:  w.konst = FRAME_CMD;
      5'd9:  w.konst = FRAME_ZERO;
      5'd10: w.src   = SRC_COLHI;
      5'd11: w.konst = FRAME_SYNC;
      5'd12: w.konst = FRAME_LEN;
      5'd13: w.konst = FRAME_CMD;
      5'd14: w.konst = FRAME_ZERO;
      5'd15: w.konst = CMD_COL_LO;
      5'd16: w.konst = FRAME_SYNC;
      5'd17: w.konst = FRAME_LEN;
      5'd18: w.konst = FRAME_DATA;
      5'd19: w.konst = FRAME_ONE;
      5'd20: begin
        w.src    = SRC_DATA;
        w.jmp    = JMP_DATA_LOOP;
        w.target = STEP_DATA;
      end
      default: w.emit = 1'b0;
    endcase
    return w;
  endfunction

endpackage

// File: sv/lptf_seq.sv
// Microcoded sequencer of the page transpose framer: step counter, data counter, control store.
// Depends on lptf_pkg for the control word types and the program.
module lptf_seq
  import lptf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              adv,
  input  logic              group_nz,
  output logic              busy,
  output lptf_step_t        step,
  output logic [DCNT_W-1:0] data_idx
);

  logic [PC_W-1:0]   pc;
  logic [DCNT_W-1:0] dcnt;
  lptf_uword_t       word;
  logic              data_end;

  // Fetch the current control word.
  always_comb begin
    word       = lptf_rom(pc);
    data_end   = (word.jmp == JMP_DATA_LOOP) && (dcnt == DATA_LAST);
    step.emit  = busy && word.emit;
    step.src   = word.src;
    step.konst = word.konst;
    step.last  = data_end;
  end

  assign data_idx = dcnt;

  // Step counter with conditional jumps; a step moves on only when the
  // output register can take its byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
      dcnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pc   <= '0;
      dcnt <= '0;
    end else if (busy && adv) begin
      unique case (word.jmp)
        JMP_NEXT: pc <= pc + 1'b1;
        JMP_IF_GROUP: pc <= group_nz ? word.target : pc + 1'b1;
        JMP_DATA_LOOP: begin
          if (data_end) begin
            busy <= 1'b0;
          end else begin
            dcnt <= dcnt + 1'b1;
            pc   <= word.target;
          end
        end
        default: pc <= pc + 1'b1;
      endcase
    end
  end

  // The program never runs past the data loop.
  assert property (@(posedge clk) disable iff (rst) busy |-> pc <= STEP_DATA)
    else $error("sequencer ran past the data loop");

  // A new run is only started while the previous one has finished.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("sequencer restarted while busy");

  // The data counter only moves inside the data loop.
  assert property (@(posedge clk) disable iff (rst)
    busy && (pc != STEP_DATA) |-> dcnt == '0)
    else $error("data counter moved outside the data loop");

endmodule

// File: sv/lcd_page_transpose_framer.sv
// Top level of the page transpose framer: input scan, tile store, output register.
// Depends on lptf_pkg and lptf_seq.
//
// Usage: framebuffer bytes enter on the pixel channel (in_valid/in_ready,
// pixel_byte, restart) in scan order: page, group of four byte columns,
// row 0..7, column in group. restart marks the first byte of a refresh.
// Each byte is stored, inverted when invert_pixels is set, in a 32-byte tile.
// Bytes that do not complete a tile are taken in one cycle each and cause
// no transfer. The byte that completes a tile starts a run of the control
// program: 46 output bytes, or 51 at group zero of a page, one per cycle
// on the output channel (out_valid/out_ready) while the receiver takes them;
// the first control word emits nothing. in_ready is low while the run goes
// on, so no byte of the next tile is taken before the run has finished.
// A stalled receiver holds the output register and freezes the program
// step; the last byte of a run may wait while new input is accepted.
// Configuration writes (cfg_valid/cfg_ready) are always taken.
// Reset clears the scan position, the registers to their defaults and the
// output channel; the tile store is not cleared.
module lcd_page_transpose_framer
  import lptf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [4:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] pixel_byte,
  input  logic       restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run,
  output logic       screen_done
);

  // Configuration registers.
  logic       invert_pixels;
  logic [3:0] width_groups;
  logic [4:0] height_pages;

  // Scan position.
  logic [2:0] row_in_tile;
  logic [1:0] column_in_group;
  logic [2:0] group_index;
  logic [3:0] page_index;

  // Position of the tile being sent.
  logic [2:0] em_group;
  logic [3:0] em_page;
  logic       em_done;

  logic [7:0] tile [4][8];

  logic       in_fire;
  logic       busy;
  logic       adv;
  lptf_step_t step;
  logic [DCNT_W-1:0] data_idx;

  logic [2:0] row0;
  logic [1:0] col0;
  logic [2:0] grp0;
  logic [3:0] pg0;
  logic [7:0] pix;
  logic       tile_end;
  logic [3:0] groups_eff;
  logic [4:0] pages_eff;
  logic [3:0] grp_inc;
  logic [4:0] pg_inc;
  logic [7:0] data_byte;
  logic [7:0] byte_sel;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign in_fire   = in_valid && in_ready;
  assign adv       = !out_valid || out_ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_pixels <= 1'b0;
      width_groups  <= 4'd4;
      height_pages  <= 5'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_INVERT: invert_pixels <= cfg_data[0];
        REG_WIDTH:  width_groups  <= cfg_data[3:0];
        REG_HEIGHT: height_pages  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Scan position after restart, clamped bounds and increments.
  always_comb begin
    row0     = restart ? '0 : row_in_tile;
    col0     = restart ? '0 : column_in_group;
    grp0     = restart ? '0 : group_index;
    pg0      = restart ? '0 : page_index;
    pix      = invert_pixels ? ~pixel_byte : pixel_byte;
    tile_end = (col0 == 2'd3) && (row0 == 3'd7);
    if (width_groups == 4'd0) begin
      groups_eff = 4'd1;
    end else if (width_groups > 4'(MAX_GROUPS)) begin
      groups_eff = 4'(MAX_GROUPS);
    end else begin
      groups_eff = width_groups;
    end
    if (height_pages == 5'd0) begin
      pages_eff = 5'd1;
    end else if (height_pages > 5'(MAX_PAGES)) begin
      pages_eff = 5'(MAX_PAGES);
    end else begin
      pages_eff = height_pages;
    end
    grp_inc = {1'b0, grp0} + 4'd1;
    pg_inc  = {1'b0, pg0} + 5'd1;
  end

  // Scan position update and capture of the tile's frame position.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_in_tile     <= '0;
      column_in_group <= '0;
      group_index     <= '0;
      page_index      <= '0;
    end else if (in_fire) begin
      column_in_group <= col0 + 2'd1;
      row_in_tile     <= (col0 == 2'd3) ? row0 + 3'd1 : row0;
      group_index     <= grp0;
      page_index      <= pg0;
      if (tile_end) begin
        if (grp_inc >= groups_eff) begin
          group_index <= '0;
          page_index  <= (pg_inc >= pages_eff) ? '0 : pg_inc[3:0];
        end else begin
          group_index <= grp_inc[2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && tile_end) begin
      em_group <= grp0;
      em_page  <= pg0;
      em_done  <= (grp_inc >= groups_eff) && (pg_inc >= pages_eff);
    end
  end

  // Tile store, one byte per column and row.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tile[col0][row0] <= pix;
    end
  end

  // Transposed data byte: bit r is bit 7-i of the row-r byte of column c.
  always_comb begin
    for (int r = 0; r < 8; r++) begin
      data_byte[r] = tile[data_idx[4:3]][r][3'd7 - data_idx[2:0]];
    end
  end

  // Output byte selection.
  always_comb begin
    case (step.src)
      SRC_CONST: byte_sel = step.konst;
      SRC_PAGE:  byte_sel = CMD_PAGE | {4'b0, em_page};
      SRC_COLHI: byte_sel = CMD_COL_HI | {4'b0, em_group, 1'b0};
      SRC_DATA:  byte_sel = data_byte;
      default:   byte_sel = step.konst;
    endcase
  end

  lptf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_fire && tile_end),
    .adv      (adv),
    .group_nz (em_group != 3'd0),
    .busy     (busy),
    .step     (step),
    .data_idx (data_idx)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step.emit && adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.emit && adv) begin
      out_byte    <= byte_sel;
      last_of_run <= step.last;
      screen_done <= step.last && em_done;
    end
  end

  // A completed tile always starts a run that blocks input.
  assert property (@(posedge clk) disable iff (rst) in_fire && tile_end |=> !in_ready)
    else $error("completed tile did not start a run");

  // A byte that leaves the tile incomplete causes no run.
  assert property (@(posedge clk) disable iff (rst) in_fire && !tile_end |=> in_ready)
    else $error("partial tile started a run");

  // End of refresh is only flagged on the last byte of a run.
  assert property (@(posedge clk) disable iff (rst) out_valid && screen_done |-> last_of_run)
    else $error("screen_done without last_of_run");

endmodule
